// File: hdl/etf_pkg.sv
// shared types, constants and helpers for the escape-time fractal pixel block
`timescale 1ns / 1ps
package etf_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 28;
	localparam int COUNT_BITS = 16;

	// z and c width (Q4.F), saturation sum width, magnitude and product widths
	localparam int ZW = FRAC_BITS + 4;
	localparam int SW = ZW + 2;
	localparam int MW = FRAC_BITS + 2;
	localparam int PW = 2 * MW;

	// register indexes
	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_LIMIT  = 3'd2;
	localparam logic [2:0] REG_KIND   = 3'd3;
	localparam logic [2:0] REG_JREAL  = 3'd4;
	localparam logic [2:0] REG_JIMAG  = 3'd5;
	localparam logic [2:0] REG_BASE   = 3'd6;

	typedef logic signed [ZW-1:0] coord_t;

	typedef struct packed {
		logic [12:0]           width;
		logic [12:0]           height;
		logic [COUNT_BITS-1:0] limit;
		logic                  kind;
		logic [31:0]           jreal;
		logic [31:0]           jimag;
		logic [23:0]           base;
	} cfg_t;

	typedef struct packed {
		coord_t zr;
		coord_t zi;
		coord_t cr;
		coord_t ci;
	} item_t;

	localparam logic signed [SW-1:0] SAT_HI = {{3{1'b0}}, {(ZW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = {{3{1'b1}}, {(ZW-1){1'b0}}};

	// clamp a wide sum to the Q4.F range
	function automatic coord_t sat_coord(input logic signed [SW-1:0] x);
		coord_t r;
		if (x > SAT_HI)
			r = {1'b0, {(ZW-1){1'b1}}};
		else if (x < SAT_LO)
			r = {1'b1, {(ZW-1){1'b0}}};
		else
			r = x[ZW-1:0];
		return r;
	endfunction

endpackage

// File: hdl/etf_front.sv
// front end: takes a pixel word and maps it onto the complex plane
`timescale 1ns / 1ps
module etf_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  etf_pkg::cfg_t                  cfg,
	input  logic                           s_valid,
	output logic                           s_ready,
	input  logic [etf_pkg::COORD_BITS-1:0] col,
	input  logic [etf_pkg::COORD_BITS-1:0] row,
	output logic                           q_valid,
	input  logic                           q_ready,
	output etf_pkg::item_t                 q_item
);
	import etf_pkg::*;

	localparam int NB  = COORD_BITS + 2;
	localparam int DW  = NB + FRAC_BITS;
	localparam int CW  = $clog2(DW + 1);
	localparam int JSL = (FRAC_BITS >= 28) ? FRAC_BITS - 28 : 0;
	localparam int JSR = (FRAC_BITS >= 28) ? 0 : 28 - FRAC_BITS;
	localparam logic signed [SW-1:0] NEG_TWO =
		-({{(SW-2){1'b0}}, 2'b10} << FRAC_BITS);
	localparam logic signed [SW-1:0] NEG_ONE_HALF =
		-({{(SW-2){1'b0}}, 2'b11} << (FRAC_BITS - 1));

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_PUSH} state_t;

	state_t         state_q;
	logic [CW-1:0]  cnt_q;
	logic           kind_q;
	logic [12:0]    wsz_q, hsz_q;
	logic [12:0]    xrem_q, yrem_q;
	logic [DW-1:0]  xdvd_q, ydvd_q, xquo_q, yquo_q;

	logic [NB-1:0]  nx, ny;
	logic [13:0]    xr1, yr1;
	logic           xge, yge;
	logic [ZW-1:0]  xoff, yoff;
	coord_t         mx, my, jr, ji;
	logic signed [63:0] jr_ext, ji_ext;

	assign s_ready = (state_q == ST_IDLE);
	assign q_valid = (state_q == ST_PUSH);

	// pixel times span
	always_comb begin
		if (cfg.kind) begin
			nx = {col, 2'b00};
			ny = {row, 2'b00};
		end else begin
			nx = {1'b0, col, 1'b0} + {2'b00, col};
			ny = {1'b0, row, 1'b0} + {2'b00, row};
		end
	end

	// one restoring division step per axis
	assign xr1 = {xrem_q, xdvd_q[DW-1]};
	assign yr1 = {yrem_q, ydvd_q[DW-1]};
	assign xge = (xr1 >= {1'b0, wsz_q});
	assign yge = (yr1 >= {1'b0, hsz_q});

	// offset with clamp of a whole part beyond 15, then start and saturation
	always_comb begin
		xoff = (|xquo_q[DW-1:FRAC_BITS+4]) ? {ZW{1'b1}} : xquo_q[ZW-1:0];
		yoff = (|yquo_q[DW-1:FRAC_BITS+4]) ? {ZW{1'b1}} : yquo_q[ZW-1:0];
		mx = sat_coord(NEG_TWO + $signed({2'b00, xoff}));
		my = sat_coord((kind_q ? NEG_TWO : NEG_ONE_HALF) + $signed({2'b00, yoff}));
		jr_ext = {{32{cfg.jreal[31]}}, cfg.jreal};
		ji_ext = {{32{cfg.jimag[31]}}, cfg.jimag};
		jr = ZW'((jr_ext <<< JSL) >>> JSR);
		ji = ZW'((ji_ext <<< JSL) >>> JSR);
		if (kind_q) begin
			q_item.zr = mx;
			q_item.zi = my;
			q_item.cr = jr;
			q_item.ci = ji;
		end else begin
			q_item.zr = '0;
			q_item.zi = '0;
			q_item.cr = mx;
			q_item.ci = my;
		end
	end

	// sequencer and divider registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_valid) begin
						kind_q <= cfg.kind;
						wsz_q  <= (cfg.width == '0) ? 13'd1 : cfg.width;
						hsz_q  <= (cfg.height == '0) ? 13'd1 : cfg.height;
						xdvd_q <= {nx, {FRAC_BITS{1'b0}}};
						ydvd_q <= {ny, {FRAC_BITS{1'b0}}};
						xrem_q <= '0;
						yrem_q <= '0;
						xquo_q <= '0;
						yquo_q <= '0;
						cnt_q  <= CW'(DW);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_PUSH;
					end else begin
						xrem_q <= xge ? 13'(xr1 - {1'b0, wsz_q}) : xr1[12:0];
						yrem_q <= yge ? 13'(yr1 - {1'b0, hsz_q}) : yr1[12:0];
						xquo_q <= {xquo_q[DW-2:0], xge};
						yquo_q <= {yquo_q[DW-2:0], yge};
						xdvd_q <= {xdvd_q[DW-2:0], 1'b0};
						ydvd_q <= {ydvd_q[DW-2:0], 1'b0};
						cnt_q  <= cnt_q - 1'b1;
					end
				end
				ST_PUSH: begin
					if (q_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/etf_queue.sv
// two-entry queue between the mapping front end and the iteration back end
`timescale 1ns / 1ps
module etf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  etf_pkg::item_t in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output etf_pkg::item_t out_item
);
	import etf_pkg::*;

	item_t       mem_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  fill_q;
	logic        push, pop;

	assign in_ready  = (fill_q != 2'd2);
	assign out_valid = (fill_q != 2'd0);
	assign out_item  = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= in_item;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: hdl/etf_back.sv
// back end: escape-time iteration, grey level division and output register
`timescale 1ns / 1ps
module etf_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  etf_pkg::cfg_t                  cfg,
	input  logic                           q_valid,
	output logic                           q_ready,
	input  etf_pkg::item_t                 q_item,
	output logic                           m_valid,
	input  logic                           m_ready,
	output logic [7:0]                     red,
	output logic [7:0]                     green,
	output logic [7:0]                     blue,
	output logic [etf_pkg::COUNT_BITS-1:0] escape_count,
	output logic                           inside_set
);
	import etf_pkg::*;

	localparam int GW  = COUNT_BITS + 8;
	localparam int GCW = $clog2(GW + 1);
	localparam logic [ZW-1:0] TWO_MAG = {{(ZW-2){1'b0}}, 2'b10} << FRAC_BITS;
	localparam logic [PW:0]   THRESH  = {{PW{1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

	typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_UPD, ST_GREY, ST_FIN} state_t;

	state_t                state_q;
	coord_t                zr_q, zi_q, cr_q, ci_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [PW-1:0]         sr_s1, si_s1, p_s1;
	logic                  nsg_s1;
	logic                  inside_q;
	logic [GW-1:0]         gdvd_q, gquo_q;
	logic [COUNT_BITS-1:0] grem_q;
	logic [GCW-1:0]        gcnt_q;
	logic                  m_valid_q;
	logic [7:0]            red_q, green_q, blue_q;
	logic [COUNT_BITS-1:0] cnt_out_q;
	logic                  inside_out_q;

	logic [ZW-1:0]         ar, ai;
	logic                  big;
	logic [PW:0]           ssum;
	logic                  neg;
	logic [PW-1:0]         d;
	logic [PW:0]           p2;
	logic [FRAC_BITS+5:0]  nr_mag, ni_mag;
	logic signed [SW-1:0]  nr, ni;
	coord_t                zr_n, zi_n;
	logic [COUNT_BITS:0]   gr1;
	logic                  gge;

	assign q_ready      = (state_q == ST_IDLE);
	assign m_valid      = m_valid_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign escape_count = cnt_out_q;
	assign inside_set   = inside_out_q;

	// magnitudes and the early bound test
	always_comb begin
		ar  = zr_q[ZW-1] ? ZW'(-zr_q) : zr_q;
		ai  = zi_q[ZW-1] ? ZW'(-zi_q) : zi_q;
		big = (ar > TWO_MAG) || (ai > TWO_MAG);
	end

	// escape test and next z from the registered products
	always_comb begin
		ssum   = {1'b0, sr_s1} + {1'b0, si_s1};
		neg    = (si_s1 > sr_s1);
		d      = neg ? (si_s1 - sr_s1) : (sr_s1 - si_s1);
		nr_mag = {2'b00, d[PW-1:FRAC_BITS]} + (FRAC_BITS+6)'(neg && (|d[FRAC_BITS-1:0]));
		nr     = neg ? -$signed(nr_mag) : $signed(nr_mag);
		p2     = {p_s1, 1'b0};
		ni_mag = {1'b0, p2[PW:FRAC_BITS]} +
			(FRAC_BITS+6)'(nsg_s1 && (|p2[FRAC_BITS-1:0]));
		ni     = nsg_s1 ? -$signed(ni_mag) : $signed(ni_mag);
		zr_n   = sat_coord(nr + {{2{cr_q[ZW-1]}}, cr_q});
		zi_n   = sat_coord(ni + {{2{ci_q[ZW-1]}}, ci_q});
	end

	// grey level division step
	assign gr1 = {grem_q, gdvd_q[GW-1]};
	assign gge = (gr1 >= {1'b0, cfg.limit});

	// sequencer, iteration registers and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			count_q   <= '0;
			gcnt_q    <= '0;
		end else begin
			if (m_valid_q && m_ready && (state_q != ST_FIN))
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						zr_q    <= q_item.zr;
						zi_q    <= q_item.zi;
						cr_q    <= q_item.cr;
						ci_q    <= q_item.ci;
						count_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (count_q == cfg.limit) begin
						inside_q <= 1'b1;
						state_q  <= ST_FIN;
					end else if (big) begin
						inside_q <= 1'b0;
						gdvd_q   <= {count_q, 8'h00} - {8'h00, count_q};
						grem_q   <= '0;
						gquo_q   <= '0;
						gcnt_q   <= GCW'(GW);
						state_q  <= ST_GREY;
					end else begin
						sr_s1   <= ar[MW-1:0] * ar[MW-1:0];
						si_s1   <= ai[MW-1:0] * ai[MW-1:0];
						p_s1    <= ar[MW-1:0] * ai[MW-1:0];
						nsg_s1  <= zr_q[ZW-1] ^ zi_q[ZW-1];
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (ssum > THRESH) begin
						inside_q <= 1'b0;
						gdvd_q   <= {count_q, 8'h00} - {8'h00, count_q};
						grem_q   <= '0;
						gquo_q   <= '0;
						gcnt_q   <= GCW'(GW);
						state_q  <= ST_GREY;
					end else begin
						zr_q    <= zr_n;
						zi_q    <= zi_n;
						count_q <= count_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_GREY: begin
					if (gcnt_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						grem_q <= gge ? COUNT_BITS'(gr1 - {1'b0, cfg.limit}) :
							gr1[COUNT_BITS-1:0];
						gquo_q <= {gquo_q[GW-2:0], gge};
						gdvd_q <= {gdvd_q[GW-2:0], 1'b0};
						gcnt_q <= gcnt_q - 1'b1;
					end
				end
				ST_FIN: begin
					if (!m_valid_q || m_ready) begin
						m_valid_q    <= 1'b1;
						cnt_out_q    <= count_q;
						inside_out_q <= inside_q;
						if (inside_q) begin
							red_q   <= cfg.base[23:16];
							green_q <= cfg.base[15:8];
							blue_q  <= cfg.base[7:0];
						end else begin
							red_q   <= gquo_q[7:0];
							green_q <= gquo_q[7:0];
							blue_q  <= gquo_q[7:0];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/escape_time_fractal_pixel_top.sv
// top level: register file, front end, queue and iteration back end
//
//  channel   dir  words                 fields
//  s_axis    in   pixel coordinate      tdata: pixel_col, pixel_row
//  m_axis    out  pixel colour          tdata: red, green, blue, escape_count; tuser: inside_set
//  apb       in   register access       7 registers at byte address 4*i
//
// the front end maps a pixel by serial division by image size
// the back end iterates in steps (multiply, then add and saturate),
// followed by a serial division for the grey level of an escaped pixel
// the queue lets the front map the next pixel while the back iterates
// arst_n clears all control state; the output word holds while m_tready is low
`timescale 1ns / 1ps
module escape_time_fractal_pixel_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pixel_col [11:0], pixel_row [23:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // red [7:0], green [15:8], blue [23:16], escape_count [39:24]
	output logic [0:0]  m_tuser    // inside_set [0]
);
	import etf_pkg::*;

	cfg_t                  cfg_q;
	logic [2:0]            idx;
	logic                  fq_valid, fq_ready, bq_valid, bq_ready;
	item_t                 f_item, b_item;
	logic [7:0]            red, green, blue;
	logic [COUNT_BITS-1:0] escape_count;
	logic                  inside_set;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= 13'd640;
			cfg_q.height <= 13'd480;
			cfg_q.limit  <= 16'd256;
			cfg_q.kind   <= 1'b0;
			cfg_q.jreal  <= '0;
			cfg_q.jimag  <= '0;
			cfg_q.base   <= 24'hFFFFFF;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_WIDTH:  cfg_q.width  <= pwdata[12:0];
				REG_HEIGHT: cfg_q.height <= pwdata[12:0];
				REG_LIMIT:  cfg_q.limit  <= pwdata[15:0];
				REG_KIND:   cfg_q.kind   <= pwdata[0];
				REG_JREAL:  cfg_q.jreal  <= pwdata;
				REG_JIMAG:  cfg_q.jimag  <= pwdata;
				REG_BASE:   cfg_q.base   <= pwdata[23:0];
				default:    ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (idx)
			REG_WIDTH:  prdata = {19'd0, cfg_q.width};
			REG_HEIGHT: prdata = {19'd0, cfg_q.height};
			REG_LIMIT:  prdata = {16'd0, cfg_q.limit};
			REG_KIND:   prdata = {31'd0, cfg_q.kind};
			REG_JREAL:  prdata = cfg_q.jreal;
			REG_JIMAG:  prdata = cfg_q.jimag;
			REG_BASE:   prdata = {8'd0, cfg_q.base};
			default:    prdata = '0;
		endcase
	end

	etf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.s_valid (s_tvalid),
		.s_ready (s_tready),
		.col     (s_tdata[11:0]),
		.row     (s_tdata[23:12]),
		.q_valid (fq_valid),
		.q_ready (fq_ready),
		.q_item  (f_item)
	);

	etf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_item   (f_item),
		.out_valid (bq_valid),
		.out_ready (bq_ready),
		.out_item  (b_item)
	);

	etf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (bq_valid),
		.q_ready      (bq_ready),
		.q_item       (b_item),
		.m_valid      (m_tvalid),
		.m_ready      (m_tready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.escape_count (escape_count),
		.inside_set   (inside_set)
	);

	assign m_tdata = {escape_count, blue, green, red};
	assign m_tuser = inside_set;

endmodule

// File: hdl/etf_checker.sv
// port-level checker for the escape-time fractal pixel block, with its bind
`timescale 1ns / 1ps
module etf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// a stalled word stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// an escaped pixel is grey
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata[7:0] == m_tdata[15:8]) &&
			(m_tdata[15:8] == m_tdata[23:16]))
		else $error("escaped pixel is not grey");

	// no word during reset
	a_reset: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output valid during reset");

	// register port never waits
	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("register port not ready");

endmodule

bind escape_time_fractal_pixel_top etf_checker u_etf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pready   (pready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
